### rtl/core/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg: shared types and constants for the wheel pulse speedometer
// Field widths, register indexes, payload structs, divider handshake and the
// control store of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package wps_pkg;

  localparam int TIME_BITS      = 48;
  localparam int SPEED_BITS     = 16;
  localparam int SCALE_BITS     = 32;
  localparam int COUNT_BITS     = 32;
  localparam int NUM_BITS       = SCALE_BITS + COUNT_BITS;
  localparam int DIV_BITS       = (TIME_BITS + SPEED_BITS > NUM_BITS) ?
                                  (TIME_BITS + SPEED_BITS) : NUM_BITS;
  localparam int DIV_CNT_BITS   = $clog2(SPEED_BITS);
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = TIME_BITS;
  localparam int STEP_BITS      = 4;

  localparam logic [SCALE_BITS-1:0] SPEED_SCALE_RESET = SCALE_BITS'(7560000);
  localparam logic [SPEED_BITS-1:0] MAX_JUMP_RESET    = SPEED_BITS'(10);
  localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET   = SPEED_BITS'(80);
  localparam logic [SPEED_BITS-1:0] MIN_SPEED_RESET   = SPEED_BITS'(1);
  localparam logic [SPEED_BITS-1:0] QUERY_LIMIT       = SPEED_BITS'(100);
  localparam logic [SPEED_BITS-1:0] QUERY_CLAMP       = SPEED_BITS'(99);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SPEED_SCALE = 3'd0,
    REG_MAX_JUMP    = 3'd1,
    REG_MAX_SPEED   = 3'd2,
    REG_MIN_SPEED   = 3'd3,
    REG_RIDE_START  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                 mode;
    logic [TIME_BITS-1:0] timestamp_us;
  } pulse_t;

  typedef struct packed {
    logic [SPEED_BITS-1:0] current_speed;
    logic [SPEED_BITS-1:0] prior_speed;
    logic [SPEED_BITS-1:0] average_speed;
    logic [COUNT_BITS-1:0] pulse_count;
    logic                  reading_rejected;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_BITS-1:0]  num;
    logic [TIME_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic [SPEED_BITS-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_LOAD_SPEED,
    UOP_TAKE_SPEED,
    UOP_UPDATE,
    UOP_MUL,
    UOP_LOAD_AVG,
    UOP_EMIT_AVG,
    UOP_EMIT_HOLD
  } uop_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_DIV_BUSY,
    COND_HOLD,
    COND_QUERY
  } cond_t;

  typedef struct packed {
    uop_t                 uop;
    cond_t                cond;
    logic [STEP_BITS-1:0] target;
  } ctrl_word_t;

  localparam logic [STEP_BITS-1:0] STEP_LOAD_SPEED = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_WAIT_SPEED = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_TAKE_SPEED = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_BRANCH     = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_UPDATE     = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_MUL        = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_LOAD_AVG   = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_WAIT_AVG   = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_EMIT_AVG   = 4'd8;
  localparam logic [STEP_BITS-1:0] STEP_EMIT_HOLD  = 4'd9;

  // Control store. Emit steps end the program.
  function automatic ctrl_word_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_word_t w;
    w = '{uop: UOP_NOP, cond: COND_NEXT, target: STEP_LOAD_SPEED};
    unique case (step)
      STEP_LOAD_SPEED: w = '{UOP_LOAD_SPEED, COND_NEXT,     STEP_LOAD_SPEED};
      STEP_WAIT_SPEED: w = '{UOP_NOP,        COND_DIV_BUSY, STEP_WAIT_SPEED};
      STEP_TAKE_SPEED: w = '{UOP_TAKE_SPEED, COND_HOLD,     STEP_EMIT_HOLD};
      STEP_BRANCH:     w = '{UOP_NOP,        COND_QUERY,    STEP_MUL};
      STEP_UPDATE:     w = '{UOP_UPDATE,     COND_NEXT,     STEP_LOAD_SPEED};
      STEP_MUL:        w = '{UOP_MUL,        COND_NEXT,     STEP_LOAD_SPEED};
      STEP_LOAD_AVG:   w = '{UOP_LOAD_AVG,   COND_NEXT,     STEP_LOAD_SPEED};
      STEP_WAIT_AVG:   w = '{UOP_NOP,        COND_DIV_BUSY, STEP_WAIT_AVG};
      STEP_EMIT_AVG:   w = '{UOP_EMIT_AVG,   COND_NEXT,     STEP_LOAD_SPEED};
      STEP_EMIT_HOLD:  w = '{UOP_EMIT_HOLD,  COND_NEXT,     STEP_LOAD_SPEED};
      default:         w = '{UOP_NOP,        COND_NEXT,     STEP_LOAD_SPEED};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/wps_div.sv
// ----------------------------------------------------------------------------
// wps_div: saturating restoring divider
// One compare decides saturation (zero divisor included), then one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wps_pkg::div_req_t req,
  output wps_pkg::div_rsp_t      rsp
);

  typedef enum logic [2:0] {
    DIV_IDLE  = 3'b001,
    DIV_CHECK = 3'b010,
    DIV_RUN   = 3'b100
  } div_state_t;

  div_state_t                          state;
  logic [wps_pkg::DIV_BITS-1:0]        rem;
  logic [wps_pkg::DIV_BITS-1:0]        dsh;
  logic [wps_pkg::SPEED_BITS-1:0]      quot;
  logic [wps_pkg::DIV_CNT_BITS-1:0]    cnt;
  logic                                ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      unique case (state)
        DIV_IDLE: begin
          if (req.start) begin
            rem   <= wps_pkg::DIV_BITS'(req.num);
            dsh   <= wps_pkg::DIV_BITS'(req.den) << wps_pkg::SPEED_BITS;
            state <= DIV_CHECK;
          end
        end
        DIV_CHECK: begin
          // quotient does not fit, or divisor is zero
          if (ge) begin
            quot  <= '1;
            state <= DIV_IDLE;
          end else begin
            quot  <= '0;
            dsh   <= dsh >> 1;
            cnt   <= wps_pkg::DIV_CNT_BITS'(wps_pkg::SPEED_BITS - 1);
            state <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          quot <= {quot[wps_pkg::SPEED_BITS-2:0], ge};
          dsh  <= dsh >> 1;
          if (cnt == '0) begin
            state <= DIV_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state != DIV_IDLE);
  assign rsp.quot = quot;

endmodule

`default_nettype wire

### rtl/core/wheel_pulse_speedometer.sv
// ----------------------------------------------------------------------------
// wheel_pulse_speedometer: speed from timestamped wheel pulses
// Plausibility-filtered speed, prior speed, pulse count and trip average,
// driven by a small microcoded sequencer around a shared serial divider.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  pulse     pulse_valid / pulse_ready  wps_pkg::pulse_t  (mode, timestamp_us)
//  result    result_valid / result_ready wps_pkg::result_t (one beat per pulse)
//  config    cfg_we                     cfg_index, cfg_data (no wait)
//
//  One beat at a time. A rejected pulse, or a query before any accepted
//  pulse, ends after the speed division; any other query adds the average
//  division, and an accepted pulse updates the state before it. Each
//  division has its load step and its wait step.
//  rst is synchronous: registers return to their defaults, state clears.
//  pulse_ready is low in reset and while the program runs; a waiting result
//  holds the final step only, a new pulse is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_pulse_speedometer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pulse_valid,
  output logic                                   pulse_ready,
  input  wire wps_pkg::pulse_t                   pulse,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output wps_pkg::result_t                       result,
  input  wire logic                              cfg_we,
  input  wire logic [wps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [wps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // configuration
  logic [wps_pkg::SCALE_BITS-1:0] speed_scale;
  logic [wps_pkg::SPEED_BITS-1:0] max_speed_jump;
  logic [wps_pkg::SPEED_BITS-1:0] max_speed;
  logic [wps_pkg::SPEED_BITS-1:0] min_speed;
  logic [wps_pkg::TIME_BITS-1:0]  ride_start_time;

  // block state
  logic [wps_pkg::TIME_BITS-1:0]  last_pulse_time;
  logic [wps_pkg::SPEED_BITS-1:0] stored_speed;
  logic [wps_pkg::SPEED_BITS-1:0] stored_prior_speed;
  logic [wps_pkg::COUNT_BITS-1:0] accepted_pulses;
  logic [wps_pkg::SPEED_BITS-1:0] stored_average;

  // sequencer and datapath
  logic                           busy;
  logic [wps_pkg::STEP_BITS-1:0]  pc;
  logic                           cur_mode;
  logic [wps_pkg::TIME_BITS-1:0]  cur_time;
  logic [wps_pkg::SPEED_BITS-1:0] speed;
  logic [wps_pkg::NUM_BITS-1:0]   product;

  wps_pkg::ctrl_word_t word;
  wps_pkg::div_req_t   div_req;
  wps_pkg::div_rsp_t   div_rsp;

  logic emit;
  logic stall;
  logic reject;
  logic jump;
  logic [wps_pkg::SPEED_BITS:0]   jump_limit;
  logic [wps_pkg::SPEED_BITS-1:0] query_speed;

  assign word        = wps_pkg::ucode(pc);
  assign pulse_ready = !busy && !rst;
  assign emit        = busy && (word.uop == wps_pkg::UOP_EMIT_AVG ||
                                word.uop == wps_pkg::UOP_EMIT_HOLD);
  assign stall       = emit && result_valid && !result_ready;

  assign jump_limit  = {1'b0, stored_speed} + {1'b0, max_speed_jump};
  assign reject      = ({1'b0, div_rsp.quot} > jump_limit) ||
                       (div_rsp.quot > max_speed) || (div_rsp.quot < min_speed);
  assign query_speed = (speed > wps_pkg::QUERY_LIMIT) ? wps_pkg::QUERY_CLAMP : speed;

  always_comb begin
    jump = 1'b0;
    case (word.cond)
      wps_pkg::COND_DIV_BUSY: jump = div_rsp.busy;
      wps_pkg::COND_HOLD:     jump = cur_mode ? (accepted_pulses == '0) : reject;
      wps_pkg::COND_QUERY:    jump = cur_mode;
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    div_req.start = busy && (word.uop == wps_pkg::UOP_LOAD_SPEED ||
                             word.uop == wps_pkg::UOP_LOAD_AVG);
    if (word.uop == wps_pkg::UOP_LOAD_SPEED) begin
      div_req.num = wps_pkg::NUM_BITS'(speed_scale);
      div_req.den = cur_time - last_pulse_time;
    end else begin
      div_req.num = product;
      div_req.den = cur_time - ride_start_time;
    end
  end

  wps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale     <= wps_pkg::SPEED_SCALE_RESET;
      max_speed_jump  <= wps_pkg::MAX_JUMP_RESET;
      max_speed       <= wps_pkg::MAX_SPEED_RESET;
      min_speed       <= wps_pkg::MIN_SPEED_RESET;
      ride_start_time <= '0;
    end else if (cfg_we) begin
      unique case (wps_pkg::cfg_reg_t'(cfg_index))
        wps_pkg::REG_SPEED_SCALE: speed_scale    <= cfg_data[wps_pkg::SCALE_BITS-1:0];
        wps_pkg::REG_MAX_JUMP:    max_speed_jump <= cfg_data[wps_pkg::SPEED_BITS-1:0];
        wps_pkg::REG_MAX_SPEED:   max_speed      <= cfg_data[wps_pkg::SPEED_BITS-1:0];
        wps_pkg::REG_MIN_SPEED:   min_speed      <= cfg_data[wps_pkg::SPEED_BITS-1:0];
        wps_pkg::REG_RIDE_START:  ride_start_time <= cfg_data[wps_pkg::TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= wps_pkg::STEP_LOAD_SPEED;
    end else if (!busy) begin
      if (pulse_valid) begin
        busy     <= 1'b1;
        pc       <= wps_pkg::STEP_LOAD_SPEED;
        cur_mode <= pulse.mode;
        cur_time <= pulse.timestamp_us;
      end
    end else if (emit) begin
      if (!stall) begin
        busy <= 1'b0;
      end
    end else if (jump) begin
      pc <= word.target;
    end else begin
      pc <= pc + 1'b1;
    end
  end

  // datapath and state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time    <= '0;
      stored_speed       <= '0;
      stored_prior_speed <= '0;
      accepted_pulses    <= '0;
      stored_average     <= '0;
    end else if (busy) begin
      case (word.uop)
        wps_pkg::UOP_TAKE_SPEED: speed <= div_rsp.quot;
        wps_pkg::UOP_UPDATE: begin
          stored_prior_speed <= stored_speed;
          stored_speed       <= speed;
          accepted_pulses    <= accepted_pulses + 1'b1;
          last_pulse_time    <= cur_time;
        end
        wps_pkg::UOP_MUL: begin
          product <= wps_pkg::NUM_BITS'(accepted_pulses) *
                     wps_pkg::NUM_BITS'(speed_scale);
        end
        wps_pkg::UOP_EMIT_AVG: begin
          if (!stall && !cur_mode) begin
            stored_average <= div_rsp.quot;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit && !stall) begin
      result_valid <= 1'b1;
      if (word.uop == wps_pkg::UOP_EMIT_AVG) begin
        result.current_speed    <= cur_mode ? query_speed : stored_speed;
        result.average_speed    <= div_rsp.quot;
        result.reading_rejected <= 1'b0;
      end else begin
        result.current_speed    <= stored_speed;
        result.average_speed    <= stored_average;
        result.reading_rejected <= !cur_mode;
      end
      result.prior_speed <= stored_prior_speed;
      result.pulse_count <= accepted_pulses;
    end else if (result_valid && result_ready) begin
      result_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_only_on_update: assert property (@(posedge clk) disable iff (rst)
    !(busy && word.uop == wps_pkg::UOP_UPDATE) |=> $stable(accepted_pulses))
    else $error("pulse count changed outside the update step");

  a_accept_starts_program: assert property (@(posedge clk) disable iff (rst)
    (pulse_valid && pulse_ready) |=> (busy && pc == wps_pkg::STEP_LOAD_SPEED))
    else $error("accepted beat did not start the program");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= wps_pkg::STEP_EMIT_HOLD))
    else $error("step counter left the program");
`endif

endmodule

`default_nettype wire
